// ===== rtl/lsl_pkg.sv =====
// ----------------------------------------------------------------------------
// lsl_pkg: shared types and constants of the two-channel lux calculator
// Item structs, region codes, Q24 region coefficients and the ratio^1.4 table.
// ----------------------------------------------------------------------------
package lsl_pkg;

    // Input item: one sample pair.
    typedef struct packed {
        logic [15:0] broadband_count;
        logic [15:0] infrared_count;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic [26:0] lux_fixed;
        logic [2:0]  ratio_region;
        logic        invalid;
    } t_out_item;

    // Ratio regions, infrared over broadband.
    typedef enum logic [2:0] {
        RGN_UPTO_050 = 3'd0,
        RGN_UPTO_061 = 3'd1,
        RGN_UPTO_080 = 3'd2,
        RGN_UPTO_130 = 3'd3,
        RGN_ABOVE    = 3'd4
    } t_region;

    // Context that travels with an item down the pipeline.
    typedef struct packed {
        logic [15:0] broadband_count;
        logic [15:0] infrared_count;
        t_region     region;
        logic        invalid;
    } t_ctx;

    localparam int          POW_W   = 15;
    localparam int          TBL_BITS = 6;
    localparam logic [26:0] LUX_MAX = 27'h7FF_FFFF;
    localparam int          COEF_SHIFT = 24;

    // Region coefficients in Q24, rounded to nearest.
    localparam logic [19:0] K_R0_BB  = 20'd510027;
    localparam logic [19:0] K_R0_POW = 20'd1040187;
    localparam logic [19:0] K_R1_BB  = 20'd375810;
    localparam logic [19:0] K_R1_IR  = 20'd520094;
    localparam logic [19:0] K_R2_BB  = 20'd214748;
    localparam logic [19:0] K_R2_IR  = 20'd256691;
    localparam logic [19:0] K_R3_BB  = 20'd24495;
    localparam logic [19:0] K_R3_IR  = 20'd18790;

    // round((k/64)^1.4 * 65536) for k = 0..32; indexes past 32 hold the last entry.
    function automatic logic [POW_W-1:0] pow14_lookup(input logic [TBL_BITS-1:0] idx);
        logic [POW_W-1:0] v;
        case (idx)
            6'd0:  v = 15'd0;
            6'd1:  v = 15'd194;
            6'd2:  v = 15'd512;
            6'd3:  v = 15'd903;
            6'd4:  v = 15'd1351;
            6'd5:  v = 15'd1847;
            6'd6:  v = 15'd2384;
            6'd7:  v = 15'd2958;
            6'd8:  v = 15'd3566;
            6'd9:  v = 15'd4205;
            6'd10: v = 15'd4873;
            6'd11: v = 15'd5569;
            6'd12: v = 15'd6290;
            6'd13: v = 15'd7036;
            6'd14: v = 15'd7806;
            6'd15: v = 15'd8597;
            6'd16: v = 15'd9410;
            6'd17: v = 15'd10244;
            6'd18: v = 15'd11097;
            6'd19: v = 15'd11970;
            6'd20: v = 15'd12861;
            6'd21: v = 15'd13770;
            6'd22: v = 15'd14697;
            6'd23: v = 15'd15640;
            6'd24: v = 15'd16601;
            6'd25: v = 15'd17577;
            6'd26: v = 15'd18569;
            6'd27: v = 15'd19577;
            6'd28: v = 15'd20599;
            6'd29: v = 15'd21636;
            6'd30: v = 15'd22688;
            6'd31: v = 15'd23754;
            default: v = 15'd24834;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/light_sensor_lux_calc_top.sv =====
// ----------------------------------------------------------------------------
// light_sensor_lux_calc_top: piecewise lux from a two-channel light sensor
// Pipelined ratio, region selection and linear lux combination per sample pair.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                     Item
//  -------  ---------  ----------------------------  -------------------------
//  in       sink       i_in_valid / o_in_ready       t_in_item  (two counts)
//  out      source     o_out_valid / i_out_ready     t_out_item (lux, region)
//
// An item enters in every cycle in which the pipeline does not stall, and
// its result passes one classify stage, one divider stage per ratio bit,
// two interpolation stages and three arithmetic stages.
// Each stage holds its own valid bit and loads whenever it is empty or the
// stage after it loads, so a stall fills bubbles first and loses nothing.
// Reset is synchronous and active low; it empties every stage.
//
module light_sensor_lux_calc_top
    import lsl_pkg::*;
#(
    parameter int RATIO_FRAC_BITS = 10,
    parameter int LUX_FRAC_BITS   = 16
)(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    // Divider chain: index 0 is the classify output, index RATIO_FRAC_BITS the
    // finished ratio. The ready of each link comes back from the stage after it.
    logic                       w_div_valid [0:RATIO_FRAC_BITS];
    logic                       w_div_ready [0:RATIO_FRAC_BITS];
    t_ctx                       w_div_ctx   [0:RATIO_FRAC_BITS];
    logic [15:0]                w_div_rem   [0:RATIO_FRAC_BITS];
    logic [RATIO_FRAC_BITS-1:0] w_div_quo   [0:RATIO_FRAC_BITS];

    logic                       w_pow_valid;
    logic                       w_pow_ready;
    t_ctx                       w_pow_ctx;
    logic [POW_W-1:0]           w_pow;

    // The region is settled by exact compares before the divider runs; the
    // ratio itself only matters in the lowest region, where the infrared
    // count is at most half the broadband count.
    lsl_classify u_classify (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_item),
        .o_valid (w_div_valid[0]),
        .i_ready (w_div_ready[0]),
        .o_ctx   (w_div_ctx[0])
    );

    // The partial remainder starts as the infrared count; each stage shifts in
    // one fraction bit of the quotient.
    assign w_div_rem[0] = w_div_ctx[0].infrared_count;
    assign w_div_quo[0] = '0;

    for (genvar g = 0; g < RATIO_FRAC_BITS; g++) begin : g_div
        lsl_div_step #(
            .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
        ) u_div_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_div_valid[g]),
            .o_ready (w_div_ready[g]),
            .i_ctx   (w_div_ctx[g]),
            .i_rem   (w_div_rem[g]),
            .i_quo   (w_div_quo[g]),
            .o_valid (w_div_valid[g+1]),
            .i_ready (w_div_ready[g+1]),
            .o_ctx   (w_div_ctx[g+1]),
            .o_rem   (w_div_rem[g+1]),
            .o_quo   (w_div_quo[g+1])
        );
    end

    // The final remainder is not needed further down.
    lsl_pow_interp #(
        .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
    ) u_pow_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_div_valid[RATIO_FRAC_BITS]),
        .o_ready (w_div_ready[RATIO_FRAC_BITS]),
        .i_ctx   (w_div_ctx[RATIO_FRAC_BITS]),
        .i_ratio (w_div_quo[RATIO_FRAC_BITS]),
        .o_valid (w_pow_valid),
        .i_ready (w_pow_ready),
        .o_ctx   (w_pow_ctx),
        .o_pow   (w_pow)
    );

    // The last stage of this unit is the output register of the block.
    lsl_lux_calc #(
        .LUX_FRAC_BITS (LUX_FRAC_BITS)
    ) u_lux_calc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_pow_valid),
        .o_ready (w_pow_ready),
        .i_ctx   (w_pow_ctx),
        .i_pow   (w_pow),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

    // An empty output register means every stage may load, so the input
    // side must be open.
    a_ready_when_drained: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready
    ) else $error("input stalled although the output register is empty");

    // Both counts zero must give zero lux in the lowest region.
    a_invalid_gives_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.invalid)
            |-> (o_out_item.lux_fixed == 27'd0
                 && o_out_item.ratio_region == RGN_UPTO_050)
    ) else $error("invalid item with non-zero lux or region");

    // Above the top threshold the lux is zero.
    a_above_gives_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.ratio_region == RGN_ABOVE)
            |-> (o_out_item.lux_fixed == 27'd0)
    ) else $error("non-zero lux above the top ratio threshold");

    // Reset empties the pipeline, so no result is shown in the cycle after it.
    a_empty_after_reset: assert property (
        @(posedge i_clk)
        !i_rst_n |=> !o_out_valid
    ) else $error("result shown right after reset");

endmodule

// ===== rtl/lsl_classify.sv =====
// ----------------------------------------------------------------------------
// lsl_classify: region selection stage
// Exact integer compares of the scaled counts pick the ratio region.
// ----------------------------------------------------------------------------
module lsl_classify
    import lsl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    output logic     o_valid,
    input  logic     i_ready,
    output t_ctx     o_ctx
);

    logic        r_valid;
    t_ctx        r_ctx;
    t_ctx        n_ctx;
    logic        w_load;
    logic [23:0] w_ir_x100;
    logic [23:0] w_bb_x50;
    logic [23:0] w_bb_x61;
    logic [23:0] w_bb_x80;
    logic [23:0] w_bb_x130;

    assign w_load  = !r_valid || i_ready;
    assign o_ready = w_load;
    assign o_valid = r_valid;
    assign o_ctx   = r_ctx;

    always_comb begin
        w_ir_x100 = 24'(i_item.infrared_count) * 24'd100;
        w_bb_x50  = 24'(i_item.broadband_count) * 24'd50;
        w_bb_x61  = 24'(i_item.broadband_count) * 24'd61;
        w_bb_x80  = 24'(i_item.broadband_count) * 24'd80;
        w_bb_x130 = 24'(i_item.broadband_count) * 24'd130;

        n_ctx.broadband_count = i_item.broadband_count;
        n_ctx.infrared_count  = i_item.infrared_count;
        n_ctx.invalid         = (i_item.broadband_count == 16'd0)
                             && (i_item.infrared_count == 16'd0);
        if (n_ctx.invalid) begin
            n_ctx.region = RGN_UPTO_050;
        end else if (i_item.broadband_count == 16'd0) begin
            n_ctx.region = RGN_ABOVE;
        end else if (w_ir_x100 <= w_bb_x50) begin
            n_ctx.region = RGN_UPTO_050;
        end else if (w_ir_x100 <= w_bb_x61) begin
            n_ctx.region = RGN_UPTO_061;
        end else if (w_ir_x100 <= w_bb_x80) begin
            n_ctx.region = RGN_UPTO_080;
        end else if (w_ir_x100 <= w_bb_x130) begin
            n_ctx.region = RGN_UPTO_130;
        end else begin
            n_ctx.region = RGN_ABOVE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ctx <= n_ctx;
        end
    end

endmodule

// ===== rtl/lsl_div_step.sv =====
// ----------------------------------------------------------------------------
// lsl_div_step: one restoring-division stage of the ratio divider
// Produces one quotient bit of (infrared << frac bits) / broadband per stage.
// ----------------------------------------------------------------------------
module lsl_div_step
    import lsl_pkg::*;
#(
    parameter int RATIO_FRAC_BITS = 10
)(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  t_ctx                       i_ctx,
    input  logic [15:0]                i_rem,
    input  logic [RATIO_FRAC_BITS-1:0] i_quo,
    output logic                       o_valid,
    input  logic                       i_ready,
    output t_ctx                       o_ctx,
    output logic [15:0]                o_rem,
    output logic [RATIO_FRAC_BITS-1:0] o_quo
);

    logic                       r_valid;
    t_ctx                       r_ctx;
    logic [15:0]                r_rem;
    logic [RATIO_FRAC_BITS-1:0] r_quo;
    logic [15:0]                n_rem;
    logic [RATIO_FRAC_BITS-1:0] n_quo;
    logic                       w_load;
    logic [16:0]                w_shift;
    logic [16:0]                w_sub;
    logic                       w_ge;

    assign w_load  = !r_valid || i_ready;
    assign o_ready = w_load;
    assign o_valid = r_valid;
    assign o_ctx   = r_ctx;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;

    // Within the lowest region the remainder always stays below the divisor.
    always_comb begin
        w_shift = {i_rem, 1'b0};
        w_sub   = w_shift - {1'b0, i_ctx.broadband_count};
        w_ge    = (w_shift >= {1'b0, i_ctx.broadband_count});
        n_rem   = w_ge ? w_sub[15:0] : w_shift[15:0];
        n_quo   = {i_quo[RATIO_FRAC_BITS-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ctx <= i_ctx;
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

endmodule

// ===== rtl/lsl_pow_interp.sv =====
// ----------------------------------------------------------------------------
// lsl_pow_interp: ratio^1.4 by table lookup and linear interpolation
// Two stages: table read and step, then the truncated interpolation.
// ----------------------------------------------------------------------------
module lsl_pow_interp
    import lsl_pkg::*;
#(
    parameter int RATIO_FRAC_BITS = 10
)(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  t_ctx                       i_ctx,
    input  logic [RATIO_FRAC_BITS-1:0] i_ratio,
    output logic                       o_valid,
    input  logic                       i_ready,
    output t_ctx                       o_ctx,
    output logic [POW_W-1:0]           o_pow
);

    localparam int SH     = RATIO_FRAC_BITS - TBL_BITS;
    localparam int FRAC_W = (SH > 0) ? SH : 1;
    localparam int PROD_W = POW_W + FRAC_W;
    localparam logic [FRAC_W-1:0] FRAC_MASK = FRAC_W'((1 << SH) - 1);

    logic                r_a_valid;
    t_ctx                r_a_ctx;
    logic [POW_W-1:0]    r_a_lo;
    logic [POW_W-1:0]    r_a_diff;
    logic [FRAC_W-1:0]   r_a_frac;
    logic                r_b_valid;
    t_ctx                r_b_ctx;
    logic [POW_W-1:0]    r_b_pow;

    logic [POW_W-1:0]    n_a_lo;
    logic [POW_W-1:0]    n_a_diff;
    logic [FRAC_W-1:0]   n_a_frac;
    logic [POW_W-1:0]    n_b_pow;

    logic                w_load_a;
    logic                w_load_b;
    logic [TBL_BITS-1:0] w_idx;
    logic [POW_W-1:0]    w_hi;
    logic [PROD_W-1:0]   w_prod;
    logic [PROD_W-1:0]   w_step;

    assign w_load_b = !r_b_valid || i_ready;
    assign w_load_a = !r_a_valid || w_load_b;
    assign o_ready  = w_load_a;
    assign o_valid  = r_b_valid;
    assign o_ctx    = r_b_ctx;
    assign o_pow    = r_b_pow;

    always_comb begin
        w_idx    = i_ratio[RATIO_FRAC_BITS-1 -: TBL_BITS];
        n_a_frac = i_ratio[FRAC_W-1:0] & FRAC_MASK;
        n_a_lo   = pow14_lookup(w_idx);
        // At the end of the table there is no next entry to step towards.
        w_hi     = w_idx[TBL_BITS-1] ? n_a_lo : pow14_lookup(w_idx + 6'd1);
        n_a_diff = w_hi - n_a_lo;
    end

    always_comb begin
        w_prod  = PROD_W'(r_a_diff) * PROD_W'(r_a_frac);
        w_step  = w_prod >> SH;
        n_b_pow = r_a_lo + w_step[POW_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (w_load_a) begin
                r_a_valid <= i_valid;
            end
            if (w_load_b) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_a) begin
            r_a_ctx  <= i_ctx;
            r_a_lo   <= n_a_lo;
            r_a_diff <= n_a_diff;
            r_a_frac <= n_a_frac;
        end
        if (w_load_b) begin
            r_b_ctx <= r_a_ctx;
            r_b_pow <= n_b_pow;
        end
    end

endmodule

// ===== rtl/lsl_lux_calc.sv =====
// ----------------------------------------------------------------------------
// lsl_lux_calc: Q24 lux arithmetic and output register
// Three stages: count times power term, coefficient products, then the clamped
// difference scaled to the output format and saturated.
// ----------------------------------------------------------------------------
module lsl_lux_calc
    import lsl_pkg::*;
#(
    parameter int LUX_FRAC_BITS = 16
)(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_ctx             i_ctx,
    input  logic [POW_W-1:0] i_pow,
    output logic             o_valid,
    input  logic             i_ready,
    output t_out_item        o_item
);

    localparam int LUX_SHIFT = COEF_SHIFT - LUX_FRAC_BITS;

    logic        r_c_valid;
    t_ctx        r_c_ctx;
    logic [30:0] r_c_prod;
    logic        r_d_valid;
    t_ctx        r_d_ctx;
    logic [35:0] r_d_pos;
    logic [35:0] r_d_neg;
    logic        r_e_valid;
    t_out_item   r_e_item;

    logic [30:0] n_c_prod;
    logic [35:0] n_d_pos;
    logic [35:0] n_d_neg;
    t_out_item   n_e_item;

    logic        w_load_c;
    logic        w_load_d;
    logic        w_load_e;
    logic [19:0] w_k_bb;
    logic [19:0] w_k_ir;
    logic [50:0] w_pow_term;
    logic [35:0] w_diff;
    logic [35:0] w_lux;

    assign w_load_e = !r_e_valid || i_ready;
    assign w_load_d = !r_d_valid || w_load_e;
    assign w_load_c = !r_c_valid || w_load_d;
    assign o_ready  = w_load_c;
    assign o_valid  = r_e_valid;
    assign o_item   = r_e_item;

    assign n_c_prod = 31'(i_ctx.broadband_count) * 31'(i_pow);

    always_comb begin
        case (r_c_ctx.region)
            RGN_UPTO_050: begin
                w_k_bb = K_R0_BB;
                w_k_ir = '0;
            end
            RGN_UPTO_061: begin
                w_k_bb = K_R1_BB;
                w_k_ir = K_R1_IR;
            end
            RGN_UPTO_080: begin
                w_k_bb = K_R2_BB;
                w_k_ir = K_R2_IR;
            end
            RGN_UPTO_130: begin
                w_k_bb = K_R3_BB;
                w_k_ir = K_R3_IR;
            end
            default: begin
                w_k_bb = '0;
                w_k_ir = '0;
            end
        endcase

        w_pow_term = 51'(K_R0_POW) * 51'(r_c_prod);
        n_d_pos    = 36'(w_k_bb) * 36'(r_c_ctx.broadband_count);
        if (r_c_ctx.region == RGN_UPTO_050) begin
            n_d_neg = 36'(w_pow_term >> 16);
        end else begin
            n_d_neg = 36'(w_k_ir) * 36'(r_c_ctx.infrared_count);
        end
        if (r_c_ctx.invalid) begin
            n_d_pos = '0;
            n_d_neg = '0;
        end
    end

    always_comb begin
        w_diff = (r_d_pos > r_d_neg) ? (r_d_pos - r_d_neg) : '0;
        w_lux  = w_diff >> LUX_SHIFT;
        n_e_item.lux_fixed    = (w_lux > 36'(LUX_MAX)) ? LUX_MAX : w_lux[26:0];
        n_e_item.ratio_region = r_d_ctx.region;
        n_e_item.invalid      = r_d_ctx.invalid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
        end else begin
            if (w_load_c) begin
                r_c_valid <= i_valid;
            end
            if (w_load_d) begin
                r_d_valid <= r_c_valid;
            end
            if (w_load_e) begin
                r_e_valid <= r_d_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_c) begin
            r_c_ctx  <= i_ctx;
            r_c_prod <= n_c_prod;
        end
        if (w_load_d) begin
            r_d_ctx <= r_c_ctx;
            r_d_pos <= n_d_pos;
            r_d_neg <= n_d_neg;
        end
        if (w_load_e) begin
            r_e_item <= n_e_item;
        end
    end

endmodule

// ===== sim/tb_light_sensor_lux_calc_top.sv =====
// ----------------------------------------------------------------------------
// tb_light_sensor_lux_calc_top: self-checking regression of the lux calculator
// Sample pairs are fed through the valid/ready input channel and each result
// item is compared, field by field, with a prediction made in the testbench.
// A short directed table comes first, then three random phases with varying
// back-pressure on both channels.
// ----------------------------------------------------------------------------
module tb_light_sensor_lux_calc_top;
    import lsl_pkg::*;

    // Block configuration, passed to the instance and used by the predictor.
    localparam int RATIO_FRAC  = 10;
    localparam int LUX_FRAC    = 16;
    localparam int INTERP_BITS = RATIO_FRAC - 6;

    // Region coefficients in Q24 and the saturation point of the lux field.
    localparam longint unsigned C_R0_BB  = 510027;
    localparam longint unsigned C_R0_POW = 1040187;
    localparam longint unsigned C_R1_BB  = 375810;
    localparam longint unsigned C_R1_IR  = 520094;
    localparam longint unsigned C_R2_BB  = 214748;
    localparam longint unsigned C_R2_IR  = 256691;
    localparam longint unsigned C_R3_BB  = 24495;
    localparam longint unsigned C_R3_IR  = 18790;
    localparam longint unsigned LUX_LIMIT = 134217727;

    // Run shaping: random items per phase, the long receiver hold-off, the
    // settling time after the last result and the watchdog limit.
    localparam int ITEMS_PER_PHASE = 476;
    localparam int LONG_HOLD       = 60;
    localparam int SETTLE_CYCLES   = 40;
    localparam int CYCLE_LIMIT     = 200000;

    // One row of the directed table. Where known is set, want is the result
    // typed in by hand; otherwise the predictor supplies the expectation.
    typedef struct packed {
        t_in_item  pair;
        logic      known;
        t_out_item want;
    } t_probe;

    localparam int        N_PROBES = 22;
    localparam t_out_item NO_WANT  = '0;

    // (k/64)^1.4 in Q16 for k = 0..32, used for the lowest region.
    int unsigned pow14_q16 [0:32] = '{
        0, 194, 512, 903, 1351, 1847, 2384, 2958,
        3566, 4205, 4873, 5569, 6290, 7036, 7806, 8597,
        9410, 10244, 11097, 11970, 12861, 13770, 14697, 15640,
        16601, 17577, 18569, 19577, 20599, 21636, 22688, 23754,
        24834
    };

    // Directed cases: both counts zero, broadband zero alone, infrared zero
    // alone, the region thresholds hit exactly and just passed, the largest
    // counts and a few ratios close to one half.
    t_probe probe_table [N_PROBES] = '{
        '{'{16'd0,     16'd0},     1'b1, '{27'd0,         RGN_UPTO_050, 1'b1}},
        '{'{16'd0,     16'd1},     1'b1, '{27'd0,         RGN_ABOVE,    1'b0}},
        '{'{16'd0,     16'd65535}, 1'b1, '{27'd0,         RGN_ABOVE,    1'b0}},
        '{'{16'd1,     16'd0},     1'b1, '{27'd1992,      RGN_UPTO_050, 1'b0}},
        '{'{16'd65535, 16'd0},     1'b1, '{27'd130564919, RGN_UPTO_050, 1'b0}},
        '{'{16'd65535, 16'd1},     1'b0, NO_WANT},
        '{'{16'd100,   16'd50},    1'b0, NO_WANT},
        '{'{16'd100,   16'd51},    1'b0, NO_WANT},
        '{'{16'd100,   16'd61},    1'b0, NO_WANT},
        '{'{16'd100,   16'd62},    1'b0, NO_WANT},
        '{'{16'd100,   16'd80},    1'b0, NO_WANT},
        '{'{16'd100,   16'd81},    1'b0, NO_WANT},
        '{'{16'd100,   16'd130},   1'b0, NO_WANT},
        '{'{16'd100,   16'd131},   1'b1, '{27'd0,         RGN_ABOVE,    1'b0}},
        '{'{16'd1,     16'd1},     1'b0, NO_WANT},
        '{'{16'd1,     16'd2},     1'b1, '{27'd0,         RGN_ABOVE,    1'b0}},
        '{'{16'd65535, 16'd65535}, 1'b0, NO_WANT},
        '{'{16'd2000,  16'd999},   1'b0, NO_WANT},
        '{'{16'hAAAA,  16'h5555},  1'b0, NO_WANT},
        '{'{16'h5555,  16'h2AAA},  1'b0, NO_WANT},
        '{'{16'd65535, 16'd32767}, 1'b0, NO_WANT},
        '{'{16'd700,   16'd455},   1'b0, NO_WANT}
    };

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_item;

    // Idling percentages for the current phase and the hold-off request.
    int unsigned send_idle_pct = 17;
    int unsigned recv_idle_pct = 81;
    bit          hold_req      = 1'b0;
    bit          hold_done     = 1'b0;
    int          hold_left     = 0;

    t_out_item   pending_lux [$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    light_sensor_lux_calc_top #(
        .RATIO_FRAC_BITS (RATIO_FRAC),
        .LUX_FRAC_BITS   (LUX_FRAC)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predicts the result item of one sample pair. The region is chosen by
    // exact integer compares; only the lowest region needs the ratio, which
    // indexes the power table and interpolates between neighbouring entries.
    function automatic t_out_item lux_of_pair(input t_in_item pair);
        longint unsigned bb, ir, ratio, idx, frac, lo, hi, pow_term;
        longint unsigned plus_term, minus_term, q24, lux;
        t_region         region;
        logic            bad;
        t_out_item       res;
        bb         = pair.broadband_count;
        ir         = pair.infrared_count;
        bad        = 1'b0;
        plus_term  = 0;
        minus_term = 0;
        if (bb == 0 && ir == 0) begin
            bad    = 1'b1;
            region = RGN_UPTO_050;
        end else if (bb == 0) begin
            region = RGN_ABOVE;
        end else if (ir * 100 <= bb * 50) begin
            region = RGN_UPTO_050;
        end else if (ir * 100 <= bb * 61) begin
            region = RGN_UPTO_061;
        end else if (ir * 100 <= bb * 80) begin
            region = RGN_UPTO_080;
        end else if (ir * 100 <= bb * 130) begin
            region = RGN_UPTO_130;
        end else begin
            region = RGN_ABOVE;
        end
        if (!bad) begin
            case (region)
                RGN_UPTO_050: begin
                    ratio = (ir << RATIO_FRAC) / bb;
                    idx   = ratio >> INTERP_BITS;
                    frac  = ratio & ((64'd1 << INTERP_BITS) - 1);
                    if (idx >= 32) begin
                        pow_term = pow14_q16[32];
                    end else begin
                        lo       = pow14_q16[idx];
                        hi       = pow14_q16[idx + 1];
                        pow_term = lo + (((hi - lo) * frac) >> INTERP_BITS);
                    end
                    plus_term  = C_R0_BB * bb;
                    minus_term = (C_R0_POW * bb * pow_term) >> 16;
                end
                RGN_UPTO_061: begin
                    plus_term  = C_R1_BB * bb;
                    minus_term = C_R1_IR * ir;
                end
                RGN_UPTO_080: begin
                    plus_term  = C_R2_BB * bb;
                    minus_term = C_R2_IR * ir;
                end
                RGN_UPTO_130: begin
                    plus_term  = C_R3_BB * bb;
                    minus_term = C_R3_IR * ir;
                end
                default: begin
                    plus_term  = 0;
                    minus_term = 0;
                end
            endcase
        end
        // Rounded coefficients can make the difference negative; it then
        // clamps to zero rather than wrapping.
        q24 = (plus_term > minus_term) ? plus_term - minus_term : 0;
        lux = q24 >> (24 - LUX_FRAC);
        if (lux > LUX_LIMIT) begin
            lux = LUX_LIMIT;
        end
        res.lux_fixed    = lux[26:0];
        res.ratio_region = region;
        res.invalid      = bad;
        return res;
    endfunction

    // Random sample pairs. Most are aimed at a region through a chosen
    // ratio, with small broadband counts favoured half of the time; the rest
    // are raw 16-bit noise, zero counts, or pairs sitting on a threshold.
    function automatic t_in_item random_pair();
        int unsigned bb, ir, k, num;
        t_in_item    pair;
        case ($urandom_range(9))
            0: begin
                bb = $urandom_range(65535);
                ir = $urandom_range(65535);
            end
            1: begin
                case ($urandom_range(2))
                    0: begin
                        bb = 0;
                        ir = 0;
                    end
                    1: begin
                        bb = 0;
                        ir = $urandom_range(65535);
                    end
                    default: begin
                        bb = $urandom_range(65535);
                        ir = 0;
                    end
                endcase
            end
            2: begin
                k = $urandom_range(1, 655);
                bb = 100 * k;
                case ($urandom_range(3))
                    0:       num = 50;
                    1:       num = 61;
                    2:       num = 80;
                    default: num = 130;
                endcase
                ir = k * num + $urandom_range(2) - 1;
            end
            default: begin
                if ($urandom_range(1) == 0) begin
                    bb = $urandom_range(1, 255);
                end else begin
                    bb = $urandom_range(1, 65535);
                end
                num = $urandom_range(1500);
                ir  = (bb * num) / 1000;
            end
        endcase
        if (ir > 65535) begin
            ir = 65535;
        end
        pair.broadband_count = bb[15:0];
        pair.infrared_count  = ir[15:0];
        return pair;
    endfunction

    // Offers one item from a falling edge, after a random number of idle
    // cycles, and returns at the falling edge after it has been accepted.
    // Valid is left high so that the next item can follow back to back.
    task automatic send_item(input t_in_item pair, input t_out_item want);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= pair;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        pending_lux.push_back(want);
        @(negedge clk);
    endtask

    // Lowers valid and waits until every expected result has come out.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_lux.size() != 0) begin
            @(negedge clk);
        end
    endtask

    task automatic report_mismatch(input string why, input t_out_item want,
                                   input t_out_item got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%s: expected lux %0d region %0d invalid %0b, got lux %0d region %0d invalid %0b",
                     why, want.lux_fixed, want.ratio_region, want.invalid,
                     got.lux_fixed, got.ratio_region, got.invalid);
        end
    endtask

    // Output side. Ready is driven at the falling edge, idling at the rate
    // of the current phase; once the hold-off has been requested it stays
    // low for a long stretch so that the pipeline fills and stalls its input.
    always @(negedge clk) begin
        if (hold_req && !hold_done) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Each result item taken at a rising edge is checked against the oldest
    // expectation, field by field.
    always @(posedge clk) begin : check_results
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_lux.size() == 0) begin
                report_mismatch("result item with nothing expected", NO_WANT, out_item);
            end else begin
                want = pending_lux.pop_front();
                if (out_item.lux_fixed !== want.lux_fixed
                        || out_item.ratio_region !== want.ratio_region
                        || out_item.invalid !== want.invalid) begin
                    report_mismatch("result item mismatch", want, out_item);
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("light_sensor_lux_calc_top regression: fail");
            $finish;
        end
    end

    initial begin : run_regression
        t_probe probe;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table, walked under the first phase's idling.
        for (int i = 0; i < N_PROBES; i++) begin
            probe = probe_table[i];
            send_item(probe.pair, probe.known ? probe.want : lux_of_pair(probe.pair));
        end
        // The sender pauses here until every expected result has come.
        drain_results();

        // Random phases: a busy receiver first, then a slow sender, then
        // neither idles. The last phase also carries the long hold-off, so
        // the input keeps offering items into a full pipeline.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 17;
                    recv_idle_pct = 81;
                end
                1: begin
                    send_idle_pct = 81;
                    recv_idle_pct = 17;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    hold_req      = 1'b1;
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin : random_item
                t_in_item pair;
                pair = random_pair();
                send_item(pair, lux_of_pair(pair));
            end
            drain_results();
        end

        // Give any stray result time to show itself before the verdict.
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && pending_lux.size() == 0) begin
            $display("light_sensor_lux_calc_top regression: pass");
        end else begin
            $display("light_sensor_lux_calc_top regression: fail");
        end
        $finish;
    end

endmodule
